// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator modules.
// Depends on nothing; each module includes it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHECK_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`define CHECK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

// ===== sv/ffsa_pkg.sv =====
// Types and constants of the first-fit segment allocator.
// Depends on nothing.
package ffsa_pkg;
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic REG_HEAP = 1'b0;
  localparam logic REG_BASE = 1'b1;
  localparam int CFG_WIDTH = 32;

  typedef struct packed {
    logic        command;
    logic [16:0] request_size;
    logic [31:0] release_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FIND, OP_SPLIT, OP_GRANT, OP_FAIL, OP_CARRY,
    OP_MARK, OP_MERGE, OP_RELDONE, OP_UNKNOWN, OP_NULL
  } op_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic can_split;
  } stat_t;
endpackage

// ===== sv/ffsa_datapath.sv =====
// Segment table, scan index and result register of the allocator.
// Depends on ffsa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffsa_datapath import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_HEAP_BYTES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  op_t              op,
  input  in_word_t         cmd,
  input  logic             cmd_load,
  input  logic             heap_load,
  input  logic [16:0]      heap_bytes,
  input  logic [31:0]      base_address,
  output stat_t            stat,
  output out_word_t        result
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [17:0] HDR = 18'(HEADER_BYTES);

  typedef struct packed {
    logic [16:0] start;
    logic [16:0] size;
    logic        free;
  } seg_t;

  seg_t          seg_mem [MAX_SEGMENTS];
  seg_t          rd;
  seg_t          cur;
  seg_t          acc;
  seg_t          wr_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] wp;
  logic [CW-1:0] hit_idx;
  in_word_t      req;
  logic [31:0]   heap_in;
  logic [17:0]   heap_sat;
  logic [16:0]   first_size;
  logic [31:0]   pay_addr;

  // The read word rd always holds the entry at idx; the merge pass sees the
  // released entry as free.
  always_comb begin
    pay_addr = base_address + 32'(rd.start) + 32'(HEADER_BYTES);
    stat.scan_end = (idx >= count);
    stat.hit = (req.command == CMD_ALLOC) ?
               (rd.free && rd.size >= req.request_size) :
               (pay_addr == req.release_address);
    stat.can_split = (18'(rd.size) > 18'(req.request_size) + HDR) &&
                     (count < CW'(MAX_SEGMENTS));
    cur = rd;
    if (idx == hit_idx) cur.free = 1'b1;

    heap_in = rst ? 32'd65536 : 32'(heap_bytes);
    heap_sat = (heap_in > 32'(MAX_HEAP_BYTES)) ? 18'(MAX_HEAP_BYTES) : 18'(heap_in);
    first_size = (heap_sat > HDR) ? 17'(heap_sat - HDR) : '0;

    unique case (op)
      OP_LOAD, OP_MARK: idx_next = '0;
      OP_FIND, OP_SPLIT, OP_CARRY, OP_MERGE: idx_next = idx + 1'b1;
      default: idx_next = idx;
    endcase

    wr_en = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = rd;
    unique case (op)
      OP_SPLIT: begin
        wr_en = 1'b1;
        wr_data = '{start: rd.start, size: req.request_size, free: 1'b0};
      end
      OP_GRANT: begin
        wr_en = 1'b1;
        wr_data = '{start: rd.start, size: rd.size, free: 1'b0};
      end
      OP_CARRY: begin
        wr_en = 1'b1;
        wr_data = acc;
      end
      OP_MERGE: begin
        if (idx != '0 && !(acc.free && cur.free)) begin
          wr_en = 1'b1;
          wr_addr = wp[IW-1:0];
          wr_data = acc;
        end
      end
      OP_RELDONE: begin
        wr_en = 1'b1;
        wr_addr = wp[IW-1:0];
        wr_data = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || heap_load) begin
      seg_mem[0] <= '{start: '0, size: first_size, free: 1'b1};
    end else if (wr_en) begin
      seg_mem[wr_addr] <= wr_data;
    end
    rd <= seg_mem[idx_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd_load) req <= cmd;
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
    if (rst || heap_load) begin
      count <= CW'(1);
    end else begin
      unique case (op)
        OP_MARK: begin
          hit_idx <= idx;
          wp <= '0;
        end
        OP_SPLIT: begin
          acc <= '{start: 17'(18'(rd.start) + HDR + 18'(req.request_size)),
                   size: 17'(18'(rd.size) - 18'(req.request_size) - HDR),
                   free: 1'b1};
        end
        OP_CARRY: begin
          if (stat.scan_end) count <= count + 1'b1;
          else acc <= rd;
        end
        OP_MERGE: begin
          if (idx == '0) begin
            acc <= cur;
          end else if (acc.free && cur.free) begin
            acc.size <= 17'(18'(acc.size) + 18'(cur.size) + HDR);
          end else begin
            wp <= wp + 1'b1;
            acc <= cur;
          end
        end
        OP_RELDONE: count <= wp + 1'b1;
        default: ;
      endcase
    end
    unique case (op)
      OP_SPLIT, OP_GRANT: result <= '{granted_address: pay_addr, status: ST_OK};
      OP_FAIL: result <= '{granted_address: '0, status: ST_NOFIT};
      OP_UNKNOWN: result <= '{granted_address: '0, status: ST_UNKNOWN};
      OP_RELDONE, OP_NULL: result <= '{granted_address: '0, status: ST_OK};
      default: ;
    endcase
  end

  `CHECK_IMPLIES(a_count_range, clk, rst, 1'b1,
                 count >= CW'(1) && count <= CW'(MAX_SEGMENTS))
  `CHECK_IMPLIES(a_split_room, clk, rst, op == OP_SPLIT,
                 count < CW'(MAX_SEGMENTS))
  `CHECK_NEXT(a_init_one, clk, rst, heap_load, count == CW'(1))
endmodule

// ===== sv/ffsa_control.sv =====
// Command sequencer of the allocator: scan, split, release and merge steps.
// Depends on ffsa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffsa_control import ffsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_word_t cmd,
  input  stat_t    stat,
  output op_t      op,
  output logic     cmd_load,
  output logic     busy,
  output logic     done
);
  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_CARRY, S_MERGE, S_OUT
  } state_t;
  state_t state;
  logic   is_rel;

  assign cmd_load = start && !busy;

  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cmd_load) begin
          if (cmd.command == CMD_RELEASE && cmd.release_address == '0) op = OP_NULL;
          else op = OP_LOAD;
        end
      end
      S_FIND: begin
        if (stat.scan_end) op = is_rel ? OP_UNKNOWN : OP_FAIL;
        else if (stat.hit) begin
          if (is_rel) op = OP_MARK;
          else if (stat.can_split) op = OP_SPLIT;
          else op = OP_GRANT;
        end else op = OP_FIND;
      end
      S_CARRY: op = OP_CARRY;
      S_MERGE: op = stat.scan_end ? OP_RELDONE : OP_MERGE;
      S_OUT: op = OP_NONE;
      default: op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      is_rel <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (op == OP_NULL) begin
          busy <= 1'b1;
          state <= S_OUT;
        end else if (op == OP_LOAD) begin
          busy <= 1'b1;
          is_rel <= (cmd.command == CMD_RELEASE);
          state <= S_FIND;
        end
        S_FIND: begin
          if (op == OP_MARK) state <= S_MERGE;
          else if (op == OP_SPLIT) state <= S_CARRY;
          else if (op != OP_FIND) state <= S_OUT;
        end
        S_CARRY: if (stat.scan_end) state <= S_OUT;
        S_MERGE: if (stat.scan_end) state <= S_OUT;
        S_OUT: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHECK_NEXT(a_out_done, clk, rst, state == S_OUT, done && !busy)
  `CHECK_IMPLIES(a_done_idle, clk, rst, done, state == S_IDLE)
  `CHECK_IMPLIES(a_idle_free, clk, rst, state == S_IDLE, !busy)
endmodule

// ===== sv/first_fit_segment_allocator_unit.sv =====
// Top level of the first-fit segment allocator: registers, sequencer, datapath.
// Depends on ffsa_pkg, ffsa_control and ffsa_datapath.
//
//   channel  | signals                      | handshake
//   command  | start, busy, cmd             | taken when start and not busy
//   result   | done, result                 | one cycle strobe, no back-pressure
//   config   | cfg_we, cfg_index, cfg_data  | taken whenever cfg_we is high
//
// A null release goes straight to the result strobe. An allocate scans the table
// for the first free entry that fits, and a release scans it for the address:
// the scan steps one entry a cycle, and a split or a release adds one more pass
// over the table. The next word is taken while the strobe is high.
// Reset is synchronous and leaves one free segment spanning the heap; a write of
// heap_bytes does the same at its writing edge. Results cannot be held off.
module first_fit_segment_allocator_unit import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_HEAP_BYTES = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  in_word_t             cmd,
  output logic                 busy,
  output logic                 done,
  output out_word_t            result,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);
  logic [31:0] base_address;
  logic        heap_load;
  op_t         op;
  stat_t       stat;
  logic        cmd_load;

  assign heap_load = cfg_we && cfg_index == REG_HEAP;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_BASE) base_address <= cfg_data;
    end
  end

  ffsa_control u_ctrl (
    .clk, .rst, .start, .cmd, .stat, .op, .cmd_load, .busy, .done
  );

  ffsa_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS), .HEADER_BYTES(HEADER_BYTES),
    .MAX_HEAP_BYTES(MAX_HEAP_BYTES)
  ) u_dp (
    .clk, .rst, .op, .cmd, .cmd_load, .heap_load, .heap_bytes(cfg_data[16:0]),
    .base_address, .stat, .result
  );
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the first-fit segment allocator unit.
// Depends on ffsa_pkg and first_fit_segment_allocator_unit; it predicts each result
// word from its own copy of the segment table and compares it with the block.
module tb;
  import ffsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = 64;
  localparam int HDR = 12;
  localparam int HEAP_MAX = 65536;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_word_t cmd = '0;
  logic busy;
  logic done;
  out_word_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_HEAP;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  first_fit_segment_allocator_unit u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Model state.
  logic [31:0] seg_off [NSEG];
  logic [31:0] seg_len [NSEG];
  logic seg_free [NSEG];
  int seg_cnt;
  logic [31:0] heap_base;
  logic [31:0] live_addrs [$];

  in_word_t pending_words [$];
  out_word_t expected_words [$];
  int cycle_count = 0;
  int failures = 0;
  bit quiet_tail = 1'b0;
  int send_gap = 0;

  function automatic void rebuild_table(logic [16:0] hb);
    logic [31:0] heap;
    heap = (hb > HEAP_MAX) ? HEAP_MAX : hb;
    for (int i = 0; i < NSEG; i++) begin
      seg_off[i] = 0;
      seg_len[i] = 0;
      seg_free[i] = 0;
    end
    seg_len[0] = (heap > HDR) ? heap - HDR : 0;
    seg_free[0] = 1'b1;
    seg_cnt = 1;
    live_addrs.delete();
  endfunction

  function automatic logic [31:0] payload_at(int i);
    return heap_base + seg_off[i] + HDR;
  endfunction

  function automatic void drop_segment(int k);
    for (int j = k; j + 1 < seg_cnt; j++) begin
      seg_off[j] = seg_off[j+1];
      seg_len[j] = seg_len[j+1];
      seg_free[j] = seg_free[j+1];
    end
    seg_cnt--;
    seg_off[seg_cnt] = 0;
    seg_len[seg_cnt] = 0;
    seg_free[seg_cnt] = 0;
  endfunction

  function automatic out_word_t allocator_outcome(in_word_t w);
    out_word_t r;
    logic [31:0] req;
    int i;
    r.granted_address = '0;
    r.status = ST_OK;
    req = w.request_size;
    if (w.command == CMD_ALLOC) begin
      r.status = ST_NOFIT;
      for (i = 0; i < seg_cnt; i++) begin
        if (seg_free[i] && seg_len[i] >= req) begin
          if (seg_len[i] > req + HDR && seg_cnt < NSEG) begin
            for (int j = seg_cnt; j > i + 1; j--) begin
              seg_off[j] = seg_off[j-1];
              seg_len[j] = seg_len[j-1];
              seg_free[j] = seg_free[j-1];
            end
            seg_off[i+1] = seg_off[i] + HDR + req;
            seg_len[i+1] = seg_len[i] - req - HDR;
            seg_free[i+1] = 1'b1;
            seg_len[i] = req;
            seg_cnt++;
          end
          seg_free[i] = 1'b0;
          r.granted_address = payload_at(i);
          r.status = ST_OK;
          live_addrs.push_back(r.granted_address);
          break;
        end
      end
    end else if (w.release_address != 0) begin
      r.status = ST_UNKNOWN;
      for (i = 0; i < seg_cnt; i++) begin
        if (payload_at(i) == w.release_address) begin
          seg_free[i] = 1'b1;
          r.status = ST_OK;
          i = 0;
          while (i + 1 < seg_cnt) begin
            if (seg_free[i] && seg_free[i+1]) begin
              seg_len[i] = seg_len[i] + seg_len[i+1] + HDR;
              drop_segment(i + 1);
            end else begin
              i++;
            end
          end
          break;
        end
      end
    end
    return r;
  endfunction

  // Command driver.
  always @(negedge clk) begin
    if (!rst && (!start || !busy)) begin
      if (send_gap > 0 || pending_words.size() == 0) begin
        if (send_gap > 0) send_gap--;
        start <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        start <= 1'b0;
      end else begin
        cmd <= pending_words.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Result monitor; a word is predicted at the edge that accepts it.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: granted_address %h status %0d",
               result.granted_address, result.status);
        failures++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (result.granted_address !== e.granted_address) begin
          $error("granted_address expected %h actual %h",
                 e.granted_address, result.granted_address);
          failures++;
        end
        if (result.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, result.status);
          failures++;
        end
      end
    end
    if (!rst && start && !busy) begin
      expected_words.push_back(allocator_outcome(cmd));
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("first_fit_segment_allocator_unit verification failed");
      $finish;
    end
  end

  task automatic drain_all();
    while (pending_words.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
    repeat (3 * NSEG + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP) rebuild_table(val[16:0]);
    else heap_base = val;
  endtask

  function automatic in_word_t alloc_word(logic [16:0] sz);
    in_word_t w;
    w.command = CMD_ALLOC;
    w.request_size = sz;
    w.release_address = $urandom;
    return w;
  endfunction

  function automatic in_word_t release_word(logic [31:0] a);
    in_word_t w;
    w.command = CMD_RELEASE;
    w.request_size = 17'($urandom);
    w.release_address = a;
    return w;
  endfunction

  // Random phase: the driver applies words one by one, so released addresses are
  // drawn from the grants that the model has seen so far when the word is queued.
  task automatic random_phase(int n, int max_size);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      while (pending_words.size() > 4) @(posedge clk);
      if (k < 50) begin
        pending_words.push_back(alloc_word(k < 3 ? 17'($urandom_range(0, 17'h1ffff))
                                              : 17'($urandom_range(0, max_size))));
      end else if (k < 90 && live_addrs.size() > 0) begin
        int p;
        p = $urandom_range(0, live_addrs.size() - 1);
        pending_words.push_back(release_word(live_addrs[p]));
        live_addrs.delete(p);
      end else if (k < 95) begin
        pending_words.push_back(release_word($urandom));
      end else begin
        pending_words.push_back(release_word(k < 97 ? 32'd0 : heap_base + HDR + 1));
      end
    end
    drain_all();
  endtask

  initial begin
    heap_base = '0;
    rebuild_table(17'h10000);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero size, null and unknown releases, double release.
    pending_words.push_back(alloc_word(17'd0));
    pending_words.push_back(alloc_word(17'h1ffff));
    pending_words.push_back(alloc_word(17'd65524));
    pending_words.push_back(release_word(32'd0));
    pending_words.push_back(release_word(32'hffffffff));
    pending_words.push_back(release_word(32'd12));
    pending_words.push_back(release_word(32'd12));
    pending_words.push_back(alloc_word(17'd100));
    pending_words.push_back(alloc_word(17'd200));
    pending_words.push_back(release_word(32'd12));
    pending_words.push_back(release_word(32'd124));
    pending_words.push_back(alloc_word(17'd65524));
    pending_words.push_back(release_word(32'd12));
    drain_all();

    write_reg(REG_HEAP, 32'h1ffff);
    write_reg(REG_BASE, 32'hfffffff4);
    pending_words.push_back(alloc_word(17'd0));
    pending_words.push_back(alloc_word(17'd4));
    pending_words.push_back(release_word(32'd0));
    pending_words.push_back(release_word(32'd16));
    drain_all();

    write_reg(REG_HEAP, 32'd16);
    write_reg(REG_BASE, 32'd0);
    pending_words.push_back(alloc_word(17'd4));
    pending_words.push_back(alloc_word(17'd0));
    pending_words.push_back(release_word(32'd12));
    drain_all();
    write_reg(REG_HEAP, 32'd5);
    pending_words.push_back(alloc_word(17'd0));
    pending_words.push_back(alloc_word(17'd1));
    drain_all();

    // Random phases: small heap that fills the table, full heap, odd base.
    write_reg(REG_HEAP, 32'd2000);
    write_reg(REG_BASE, $urandom);
    random_phase(400, 40);
    write_reg(REG_HEAP, 32'd65536);
    write_reg(REG_BASE, 32'hffff0000);
    random_phase(400, 3000);
    write_reg(REG_HEAP, $urandom_range(16, 65536));
    write_reg(REG_BASE, 32'h80000000);
    random_phase(450, 600);
    quiet_tail = 1'b1;
    write_reg(REG_HEAP, 32'd1200);
    write_reg(REG_BASE, 32'h0);
    random_phase(450, 30);

    if (failures == 0) begin
      $display("first_fit_segment_allocator_unit verification clean");
    end else begin
      $display("first_fit_segment_allocator_unit verification failed");
    end
    $finish;
  end
endmodule
